[rtl/core/cell_moment_vector_accumulator_top_macros.svh]
// assertion macros for the cell moment vector accumulator
// no dependencies; included by the files that carry concurrent assertions
`ifndef CELL_MOMENT_VECTOR_ACCUMULATOR_TOP_MACROS_SVH
`define CELL_MOMENT_VECTOR_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CMVA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CMVA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cmva_pkg.sv]
// types and fixed constants of the cell moment vector accumulator
// no dependencies; imported by cell_moment_vector_accumulator_top
package cmva_pkg;

    // input field widths
    localparam int REQ_W      = 2;
    localparam int CELL_IDX_W = 10;
    localparam int MAT_IDX_W  = 4;
    localparam int ROW_IDX_W  = 2;
    localparam int FIELD_W    = 16;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ACCUM = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd2;

    // arithmetic widths
    localparam int PP_W       = 2 * FIELD_W;        // coef * spin
    localparam int ACC_W      = PP_W + 2;           // sum of three products
    localparam int TS_SHIFT   = 14;                 // 2^-29 -> 2^-15
    localparam int Q_W        = ACC_W - TS_SHIFT;
    localparam int TS_W       = 17;                 // transformed spin, Q2.15
    localparam int MAG_PROD_W = FIELD_W + 1 + FIELD_W;
    localparam int PROD_W     = FIELD_W + 1 + TS_W;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(8192);

    // transform row storage: three lanes of three coefficients
    localparam int NUM_ROWS  = 3;
    localparam int TM_LANE_W = 3 * FIELD_W;
    localparam int TM_ROW_W  = NUM_ROWS * TM_LANE_W;
    localparam logic [TM_ROW_W-1:0] TM_IDENT = {
        16'h4000, 16'h0000, 16'h0000,
        16'h0000, 16'h4000, 16'h0000,
        16'h0000, 16'h0000, 16'h4000
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_ADD,
        ST_READ
    } t_state;

endpackage

[rtl/core/cell_moment_vector_accumulator_top.sv]
// cell moment vector accumulator: per-cell magnetisation and staggered sums
// depends on cmva_pkg and cell_moment_vector_accumulator_top_macros.svh
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  request  | start / busy           | i_req_type .. i_coef_2
//  result   | o_result_valid strobe  | o_mag_sum_x/y/z, o_stag_sum_x/y/z
//
// accumulate: table read, coef products, rounding, moment products, saturating add
//   and write-back into the sum memory
// read and clear: the result strobes in the cycle in which busy drops
// write transform row: busy stays low
// after reset a clearing pass zeroes the sum memory and loads identity transforms;
//   busy is high throughout
// busy interlocks the read-modify-write, so no two transactions touch a row at once
// the receiver cannot stall; each result is shown for exactly one cycle
`include "cell_moment_vector_accumulator_top_macros.svh"

module cell_moment_vector_accumulator_top #(
    parameter int CELL_COUNT    = 1024,
    parameter int NUM_MATERIALS = 16,
    parameter int SUM_WIDTH     = 40
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [cmva_pkg::REQ_W-1:0]             i_req_type,
    input  logic [cmva_pkg::CELL_IDX_W-1:0]        i_cell_index,
    input  logic [cmva_pkg::MAT_IDX_W-1:0]         i_material_index,
    input  logic [cmva_pkg::FIELD_W-1:0]           i_moment,
    input  logic signed [cmva_pkg::FIELD_W-1:0]    i_spin_x,
    input  logic signed [cmva_pkg::FIELD_W-1:0]    i_spin_y,
    input  logic signed [cmva_pkg::FIELD_W-1:0]    i_spin_z,
    input  logic [cmva_pkg::ROW_IDX_W-1:0]         i_matrix_row,
    input  logic signed [cmva_pkg::FIELD_W-1:0]    i_coef_0,
    input  logic signed [cmva_pkg::FIELD_W-1:0]    i_coef_1,
    input  logic signed [cmva_pkg::FIELD_W-1:0]    i_coef_2,
    output logic                                   o_result_valid,
    output logic signed [SUM_WIDTH-1:0]            o_mag_sum_x,
    output logic signed [SUM_WIDTH-1:0]            o_mag_sum_y,
    output logic signed [SUM_WIDTH-1:0]            o_mag_sum_z,
    output logic signed [SUM_WIDTH-1:0]            o_stag_sum_x,
    output logic signed [SUM_WIDTH-1:0]            o_stag_sum_y,
    output logic signed [SUM_WIDTH-1:0]            o_stag_sum_z
);
    import cmva_pkg::*;

    localparam int CELL_AW   = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int MAT_AW    = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;
    localparam int CLR_LEN   = (CELL_COUNT > NUM_MATERIALS) ? CELL_COUNT : NUM_MATERIALS;
    localparam int CLR_W     = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;
    localparam int SUM_ROW_W = 6 * SUM_WIDTH;
    localparam int EXT_W     = ((SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W) + 1;

    t_state                      r_state, n_state;
    logic [CLR_W-1:0]            r_clr_cnt;

    logic                        w_accept;
    logic                        w_cell_ok, w_mat_ok, w_row_ok;
    logic                        w_acc_go;
    logic [CELL_AW-1:0]          w_cell_addr;
    logic [MAT_AW-1:0]           w_mat_addr;

    // transaction registers
    logic [CELL_AW-1:0]          r_cell_addr;
    logic                        r_cell_ok;
    logic [FIELD_W-1:0]          r_moment;
    logic signed [FIELD_W-1:0]   r_spin [3];

    // memories and their registered read data
    logic [SUM_ROW_W-1:0]        r_sum_mem [CELL_COUNT];
    logic [TM_ROW_W-1:0]         r_tm_mem  [NUM_MATERIALS];
    logic [SUM_ROW_W-1:0]        r_sum_q;
    logic [TM_ROW_W-1:0]         r_tm_q;

    // datapath
    logic signed [PP_W-1:0]       r_prod      [9];
    logic signed [TS_W-1:0]       r_ts        [3];
    logic signed [TS_W-1:0]       n_ts        [3];
    logic signed [MAG_PROD_W-1:0] r_mag_prod  [3];
    logic signed [PROD_W-1:0]     r_stag_prod [3];
    logic [SUM_ROW_W-1:0]         w_sum_new;

    // memory write ports
    logic                        w_sum_we;
    logic [CELL_AW-1:0]          w_sum_waddr;
    logic [SUM_ROW_W-1:0]        w_sum_wdata;
    logic [NUM_ROWS-1:0]         w_tm_we;
    logic [MAT_AW-1:0]           w_tm_waddr;
    logic [TM_ROW_W-1:0]         w_tm_wdata;

    logic                        r_out_valid;
    logic [SUM_ROW_W-1:0]        r_out_data;

    function automatic logic signed [SUM_WIDTH-1:0] f_sat_add(
        input logic signed [SUM_WIDTH-1:0] acc,
        input logic signed [PROD_W-1:0]    add
    );
        logic signed [EXT_W-1:0] s;
        s = EXT_W'(acc) + EXT_W'(add);
        if (s[EXT_W-1:SUM_WIDTH-1] == {(EXT_W-SUM_WIDTH+1){s[EXT_W-1]}}) begin
            return s[SUM_WIDTH-1:0];
        end else if (s[EXT_W-1]) begin
            return {1'b1, {(SUM_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end
    endfunction

    assign w_accept    = start && !busy;
    assign w_cell_ok   = 32'(i_cell_index) < 32'(CELL_COUNT);
    assign w_mat_ok    = 32'(i_material_index) < 32'(NUM_MATERIALS);
    assign w_row_ok    = 32'(i_matrix_row) < 32'(NUM_ROWS);
    assign w_acc_go    = w_accept && (i_req_type == REQ_ACCUM) && w_cell_ok && w_mat_ok;
    assign w_cell_addr = CELL_AW'(i_cell_index);
    assign w_mat_addr  = MAT_AW'(i_material_index);

    // ---------------- control ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_READ);
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == CLR_W'(CLR_LEN - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc_go) begin
                    n_state = ST_MUL;
                end else if (w_accept && (i_req_type == REQ_READ)) begin
                    n_state = ST_READ;
                end
            end
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ADD;
            ST_ADD:   n_state = ST_IDLE;
            ST_READ:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state != ST_IDLE);
        w_sum_we    = 1'b0;
        w_sum_waddr = r_cell_addr;
        w_sum_wdata = '0;
        w_tm_we     = '0;
        w_tm_waddr  = w_mat_addr;
        w_tm_wdata  = {NUM_ROWS{i_coef_2, i_coef_1, i_coef_0}};
        unique case (r_state)
            ST_CLEAR: begin
                w_sum_we    = 32'(r_clr_cnt) < 32'(CELL_COUNT);
                w_sum_waddr = CELL_AW'(r_clr_cnt);
                w_tm_we     = (32'(r_clr_cnt) < 32'(NUM_MATERIALS)) ? '1 : '0;
                w_tm_waddr  = MAT_AW'(r_clr_cnt);
                w_tm_wdata  = TM_IDENT;
            end
            ST_IDLE: begin
                if (w_accept && (i_req_type == REQ_WRITE) && w_mat_ok && w_row_ok) begin
                    w_tm_we = NUM_ROWS'(1) << i_matrix_row;
                end
            end
            ST_ADD: begin
                w_sum_we    = 1'b1;
                w_sum_wdata = w_sum_new;
            end
            ST_READ: begin
                // clear on read, out-of-range cells leave memory alone
                w_sum_we = r_cell_ok;
            end
            ST_MUL, ST_SUM, ST_SCALE: begin
            end
        endcase
    end

    // ---------------- memories ----------------

    always_ff @(posedge i_clk) begin
        if (w_sum_we) begin
            r_sum_mem[w_sum_waddr] <= w_sum_wdata;
        end
        if (w_accept) begin
            r_sum_q <= r_sum_mem[w_cell_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_ROWS; j++) begin
            if (w_tm_we[j]) begin
                r_tm_mem[w_tm_waddr][j*TM_LANE_W +: TM_LANE_W] <=
                    w_tm_wdata[j*TM_LANE_W +: TM_LANE_W];
            end
        end
        if (w_accept) begin
            r_tm_q <= r_tm_mem[w_mat_addr];
        end
    end

    // ---------------- datapath ----------------

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cell_addr <= w_cell_addr;
            r_cell_ok   <= w_cell_ok;
            r_moment    <= i_moment;
            r_spin[0]   <= i_spin_x;
            r_spin[1]   <= i_spin_y;
            r_spin[2]   <= i_spin_z;
        end
    end

    // operands stay put for the whole transaction, so the stages run freely
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_prod[k] <= $signed(r_tm_q[k*FIELD_W +: FIELD_W]) * r_spin[k%3];
        end
        for (int j = 0; j < 3; j++) begin
            r_ts[j]        <= n_ts[j];
            r_mag_prod[j]  <= $signed({1'b0, r_moment}) * r_spin[j];
            r_stag_prod[j] <= $signed({1'b0, r_moment}) * r_ts[j];
        end
    end

    // round half up to Q2.15 and saturate
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic signed [Q_W-1:0]   q;
        for (int j = 0; j < 3; j++) begin
            acc = ACC_W'(r_prod[3*j]) + ACC_W'(r_prod[3*j+1]) + ACC_W'(r_prod[3*j+2])
                + ROUND_BIAS;
            q   = acc[ACC_W-1:TS_SHIFT];
            if (q[Q_W-1:TS_W-1] == {(Q_W-TS_W+1){q[Q_W-1]}}) begin
                n_ts[j] = q[TS_W-1:0];
            end else if (q[Q_W-1]) begin
                n_ts[j] = {1'b1, {(TS_W-1){1'b0}}};
            end else begin
                n_ts[j] = {1'b0, {(TS_W-1){1'b1}}};
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_sum_new[j*SUM_WIDTH +: SUM_WIDTH] =
                f_sat_add(r_sum_q[j*SUM_WIDTH +: SUM_WIDTH], PROD_W'(r_mag_prod[j]));
            w_sum_new[(j+3)*SUM_WIDTH +: SUM_WIDTH] =
                f_sat_add(r_sum_q[(j+3)*SUM_WIDTH +: SUM_WIDTH], r_stag_prod[j]);
        end
    end

    // ---------------- result ----------------

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_out_data <= r_cell_ok ? r_sum_q : '0;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_mag_sum_x    = r_out_data[0*SUM_WIDTH +: SUM_WIDTH];
    assign o_mag_sum_y    = r_out_data[1*SUM_WIDTH +: SUM_WIDTH];
    assign o_mag_sum_z    = r_out_data[2*SUM_WIDTH +: SUM_WIDTH];
    assign o_stag_sum_x   = r_out_data[3*SUM_WIDTH +: SUM_WIDTH];
    assign o_stag_sum_y   = r_out_data[4*SUM_WIDTH +: SUM_WIDTH];
    assign o_stag_sum_z   = r_out_data[5*SUM_WIDTH +: SUM_WIDTH];

    // ---------------- assertions ----------------

    `CMVA_ASSERT_NXT(a_result_after_read, i_clk, i_rst_n,
        r_state == ST_READ, r_out_valid,
        "read transaction produced no result strobe")
    `CMVA_ASSERT_NXT(a_result_single, i_clk, i_rst_n,
        r_out_valid, !r_out_valid,
        "result strobe held for more than one cycle")
    `CMVA_ASSERT_IMP(a_sum_write_busy, i_clk, i_rst_n,
        w_sum_we, busy,
        "sum memory written while idle")
    `CMVA_ASSERT_IMP(a_acc_writeback, i_clk, i_rst_n,
        $past(w_acc_go, 4), r_state == ST_ADD,
        "accumulate write-back not four cycles after acceptance")

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// testbench for cell_moment_vector_accumulator_top: directed and random transactions
// checked against an in-bench model of the per-cell sums and transform table
// depends on cmva_pkg and the rtl top level
module tb;
    import cmva_pkg::*;

    localparam int CELL_COUNT   = 1024;
    localparam int NUM_MATS     = 16;
    localparam int SUM_W        = 40;
    localparam longint SUM_HI   = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO   = -SUM_HI - 1;
    localparam longint TS_HI    = 65535;
    localparam longint TS_LO    = -65536;
    localparam longint TS_BIAS  = 8192;
    localparam int IDENT_COEF   = 16384;
    localparam int CYC_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RAND_ITEMS   = 1900;
    localparam int MAX_PRINTS   = 50;

    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [ROW_IDX_W-1:0] ROW_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]             req;
        logic [CELL_IDX_W-1:0]        cell_idx;
        logic [MAT_IDX_W-1:0]         mat;
        logic [FIELD_W-1:0]           moment;
        logic signed [FIELD_W-1:0]    spin_x;
        logic signed [FIELD_W-1:0]    spin_y;
        logic signed [FIELD_W-1:0]    spin_z;
        logic [ROW_IDX_W-1:0]         row;
        logic signed [FIELD_W-1:0]    coef_0;
        logic signed [FIELD_W-1:0]    coef_1;
        logic signed [FIELD_W-1:0]    coef_2;
        bit                           drain;
    } t_atom_req;

    // lanes 0..2 magnetisation x/y/z, lanes 3..5 staggered x/y/z
    typedef logic [5:0][SUM_W-1:0] t_cell_sums;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [REQ_W-1:0]          i_req_type = '0;
    logic [CELL_IDX_W-1:0]     i_cell_index = '0;
    logic [MAT_IDX_W-1:0]      i_material_index = '0;
    logic [FIELD_W-1:0]        i_moment = '0;
    logic signed [FIELD_W-1:0] i_spin_x = '0;
    logic signed [FIELD_W-1:0] i_spin_y = '0;
    logic signed [FIELD_W-1:0] i_spin_z = '0;
    logic [ROW_IDX_W-1:0]      i_matrix_row = '0;
    logic signed [FIELD_W-1:0] i_coef_0 = '0;
    logic signed [FIELD_W-1:0] i_coef_1 = '0;
    logic signed [FIELD_W-1:0] i_coef_2 = '0;
    logic                      o_result_valid;
    logic signed [SUM_W-1:0]   o_mag_sum_x;
    logic signed [SUM_W-1:0]   o_mag_sum_y;
    logic signed [SUM_W-1:0]   o_mag_sum_z;
    logic signed [SUM_W-1:0]   o_stag_sum_x;
    logic signed [SUM_W-1:0]   o_stag_sum_y;
    logic signed [SUM_W-1:0]   o_stag_sum_z;

    // model state
    longint cell_mag [CELL_COUNT*3];
    longint cell_stag [CELL_COUNT*3];
    longint xform_coef [NUM_MATS*9];

    t_atom_req  atom_reqs [$];
    t_cell_sums sums_due [$];
    t_atom_req  drv_req;
    t_cell_sums got_sums;
    t_cell_sums want_sums;
    bit         took = 1'b0;
    int         burst_left = 0;
    int         gap_left = 0;
    int         err_cnt = 0;
    int         cyc_cnt = 0;
    logic [CELL_IDX_W-1:0] hot_cell [8];
    string lane_name [6] = '{"mag_sum_x", "mag_sum_y", "mag_sum_z",
                             "stag_sum_x", "stag_sum_y", "stag_sum_z"};

    cell_moment_vector_accumulator_top #(
        .CELL_COUNT    (CELL_COUNT),
        .NUM_MATERIALS (NUM_MATS),
        .SUM_WIDTH     (SUM_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_cell_index     (i_cell_index),
        .i_material_index (i_material_index),
        .i_moment         (i_moment),
        .i_spin_x         (i_spin_x),
        .i_spin_y         (i_spin_y),
        .i_spin_z         (i_spin_z),
        .i_matrix_row     (i_matrix_row),
        .i_coef_0         (i_coef_0),
        .i_coef_1         (i_coef_1),
        .i_coef_2         (i_coef_2),
        .o_result_valid   (o_result_valid),
        .o_mag_sum_x      (o_mag_sum_x),
        .o_mag_sum_y      (o_mag_sum_y),
        .o_mag_sum_z      (o_mag_sum_z),
        .o_stag_sum_x     (o_stag_sum_x),
        .o_stag_sum_y     (o_stag_sum_y),
        .o_stag_sum_z     (o_stag_sum_z)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (err_cnt < MAX_PRINTS) begin
            $display("[%0t] ERROR %s", $time, msg);
        end
        err_cnt++;
    endtask

    function automatic longint sat_add(input longint acc, input longint add);
        if (add > 0 && acc > SUM_HI - add) return SUM_HI;
        if (add < 0 && acc < SUM_LO - add) return SUM_LO;
        return acc + add;
    endfunction

    // update the model for one accepted transaction, queue the read result
    function automatic void apply_request(input t_atom_req r);
        longint sp [3];
        longint acc;
        longint ts;
        longint mom;
        int k;
        t_cell_sums due;
        sp[0] = r.spin_x;
        sp[1] = r.spin_y;
        sp[2] = r.spin_z;
        mom = r.moment;
        due = '0;
        case (r.req)
            REQ_ACCUM: begin
                if (r.cell_idx < CELL_COUNT && r.mat < NUM_MATS) begin
                    for (int j = 0; j < 3; j++) begin
                        acc = 0;
                        for (int c = 0; c < 3; c++) begin
                            acc += xform_coef[r.mat * 9 + j * 3 + c] * sp[c];
                        end
                        // round half up to Q2.15, then clamp to 17 bits
                        ts = (acc + TS_BIAS) >>> TS_SHIFT;
                        if (ts > TS_HI) ts = TS_HI;
                        if (ts < TS_LO) ts = TS_LO;
                        k = r.cell_idx * 3 + j;
                        cell_mag[k]  = sat_add(cell_mag[k], mom * sp[j]);
                        cell_stag[k] = sat_add(cell_stag[k], mom * ts);
                    end
                end
            end
            REQ_READ: begin
                if (r.cell_idx < CELL_COUNT) begin
                    for (int j = 0; j < 3; j++) begin
                        k = r.cell_idx * 3 + j;
                        due[j]     = SUM_W'(cell_mag[k]);
                        due[3 + j] = SUM_W'(cell_stag[k]);
                        cell_mag[k]  = 0;
                        cell_stag[k] = 0;
                    end
                end
                sums_due.push_back(due);
            end
            REQ_WRITE: begin
                if (r.mat < NUM_MATS && r.row < NUM_ROWS) begin
                    xform_coef[r.mat * 9 + r.row * 3 + 0] = r.coef_0;
                    xform_coef[r.mat * 9 + r.row * 3 + 1] = r.coef_1;
                    xform_coef[r.mat * 9 + r.row * 3 + 2] = r.coef_2;
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] big_spin(input bit neg);
        if (neg) return 16'(-$urandom_range(28000, 32768));
        return 16'($urandom_range(28000, 32767));
    endfunction

    function automatic t_atom_req rand_req();
        t_atom_req r;
        r.req      = REQ_W'($urandom());
        r.cell_idx = CELL_IDX_W'($urandom());
        r.mat      = MAT_IDX_W'($urandom());
        r.moment   = pick_word();
        r.spin_x   = pick_word();
        r.spin_y   = pick_word();
        r.spin_z   = pick_word();
        r.row      = ROW_IDX_W'($urandom());
        r.coef_0   = pick_word();
        r.coef_1   = pick_word();
        r.coef_2   = pick_word();
        r.drain    = 1'b0;
        return r;
    endfunction

    task automatic push_accum(input logic [CELL_IDX_W-1:0] cell_no,
                              input logic [MAT_IDX_W-1:0] mat_no,
                              input logic [FIELD_W-1:0] mom, sx, sy, sz);
        t_atom_req r;
        r = rand_req();
        r.req      = REQ_ACCUM;
        r.cell_idx = cell_no;
        r.mat      = mat_no;
        r.moment   = mom;
        r.spin_x   = sx;
        r.spin_y   = sy;
        r.spin_z   = sz;
        atom_reqs.push_back(r);
    endtask

    task automatic push_read(input logic [CELL_IDX_W-1:0] cell_no);
        t_atom_req r;
        r = rand_req();
        r.req      = REQ_READ;
        r.cell_idx = cell_no;
        atom_reqs.push_back(r);
    endtask

    task automatic push_write(input logic [MAT_IDX_W-1:0] mat_no,
                              input logic [ROW_IDX_W-1:0] row_no,
                              input logic [FIELD_W-1:0] c0, c1, c2);
        t_atom_req r;
        r = rand_req();
        r.req    = REQ_WRITE;
        r.mat    = mat_no;
        r.row    = row_no;
        r.coef_0 = c0;
        r.coef_1 = c1;
        r.coef_2 = c2;
        atom_reqs.push_back(r);
    endtask

    // driver: bursts of transactions with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // hold the transaction until busy lets it in
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end else if (atom_reqs.size() == 0 ||
                     (atom_reqs[0].drain && sums_due.size() != 0)) begin
            start <= 1'b0;
        end else begin
            drv_req = atom_reqs.pop_front();
            start            <= 1'b1;
            i_req_type       <= drv_req.req;
            i_cell_index     <= drv_req.cell_idx;
            i_material_index <= drv_req.mat;
            i_moment         <= drv_req.moment;
            i_spin_x         <= drv_req.spin_x;
            i_spin_y         <= drv_req.spin_y;
            i_spin_z         <= drv_req.spin_z;
            i_matrix_row     <= drv_req.row;
            i_coef_0         <= drv_req.coef_0;
            i_coef_1         <= drv_req.coef_1;
            i_coef_2         <= drv_req.coef_2;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // monitor: check results, then feed accepted transactions to the model
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took = 1'b0;
        end else begin
            if (o_result_valid) begin
                if (sums_due.size() == 0) begin
                    report_error("result strobe with no read outstanding");
                end else begin
                    want_sums = sums_due.pop_front();
                    got_sums  = {o_stag_sum_z, o_stag_sum_y, o_stag_sum_x,
                                 o_mag_sum_z, o_mag_sum_y, o_mag_sum_x};
                    for (int j = 0; j < 6; j++) begin
                        if (got_sums[j] !== want_sums[j]) begin
                            report_error($sformatf("%s got %0d want %0d", lane_name[j],
                                                   $signed(got_sums[j]),
                                                   $signed(want_sums[j])));
                        end
                    end
                end
            end
            took = start && !busy;
            if (took) apply_request(drv_req);
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYC_LIMIT) begin
            $display("timeout after %0d cycles", cyc_cnt);
            $display("FAIL cell_moment_vector_accumulator_top");
            $finish;
        end
    end

    initial begin
        t_atom_req r;
        int counted;
        int sel;
        int n;
        logic [CELL_IDX_W-1:0] c;
        logic [MAT_IDX_W-1:0] m;
        logic [FIELD_W-1:0] cf;
        bit neg;

        for (int k = 0; k < CELL_COUNT * 3; k++) begin
            cell_mag[k]  = 0;
            cell_stag[k] = 0;
        end
        for (int k = 0; k < NUM_MATS * 9; k++) begin
            xform_coef[k] = (k % 9 == 0 || k % 9 == 4 || k % 9 == 8) ? IDENT_COEF : 0;
        end

        // directed: extremes, every request type, ignored rows and types, rounding
        push_accum(0, 0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_accum(0, 0, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        push_accum(0, 0, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000);
        push_read(0);
        push_write(1, 0, 16'h8000, 16'h8000, 16'h8000);
        push_write(1, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_write(1, 2, 16'h0001, 16'h0000, 16'h0000);
        push_write(1, ROW_UNUSED, 16'h0000, 16'h0000, 16'h0000);
        r = rand_req();
        r.req = REQ_UNUSED;
        r.cell_idx = CELL_IDX_W'(CELL_COUNT - 1);
        atom_reqs.push_back(r);
        // transformed spin saturates both ways, then rounding ties on row 2
        push_accum(CELL_IDX_W'(CELL_COUNT - 1), 1, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
        push_accum(CELL_IDX_W'(CELL_COUNT - 1), 1, 16'h0001, 16'h2000, 16'h0000, 16'h0000);
        push_accum(CELL_IDX_W'(CELL_COUNT - 1), 1, 16'h0001, 16'hE000, 16'h0000, 16'h0000);
        push_accum(CELL_IDX_W'(CELL_COUNT - 1), 1, 16'h0001, 16'hA000, 16'h0000, 16'h0000);
        push_accum(CELL_IDX_W'(CELL_COUNT - 1), 15, 16'h0000, 16'h7FFF, 16'h8000, 16'h1234);
        push_read(CELL_IDX_W'(CELL_COUNT - 1));
        push_read(CELL_IDX_W'(CELL_COUNT - 1));
        push_write(15, 2, 16'h7FFF, 16'h8000, 16'h4000);
        push_accum(512, 15, 16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF);
        push_read(512);
        push_read(777);

        foreach (hot_cell[h]) hot_cell[h] = CELL_IDX_W'($urandom());
        counted = 0;
        while (counted < RAND_ITEMS) begin
            if (counted == 500 || counted == 1200) begin
                // same-sign atoms into one cell with a steep transform until both
                // sums pin at the rail, then read it back
                neg = (counted == 1200);
                c  = CELL_IDX_W'($urandom());
                m  = MAT_IDX_W'($urandom());
                cf = neg ? 16'h8000 : 16'h7FFF;
                for (int row = 0; row < NUM_ROWS; row++) begin
                    push_write(m, ROW_IDX_W'(row), cf, cf, cf);
                end
                n = $urandom_range(380, 460);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        push_accum(c, m, pick_word(), pick_word(), pick_word(), pick_word());
                    end else begin
                        push_accum(c, m, 16'($urandom_range(16'hE000, 16'hFFFF)),
                                   big_spin(neg), big_spin(neg), big_spin(neg));
                    end
                end
                push_read(c);
                counted += n + NUM_ROWS + 1;
            end else begin
                r = rand_req();
                sel = $urandom_range(0, 99);
                if ($urandom_range(0, 3) != 0) r.cell_idx = hot_cell[$urandom_range(0, 7)];
                if (sel < 68) begin
                    r.req = REQ_ACCUM;
                end else if (sel < 82) begin
                    r.req = REQ_READ;
                end else if (sel < 96) begin
                    r.req = REQ_WRITE;
                    if ($urandom_range(0, 19) != 0) r.row = ROW_IDX_W'($urandom_range(0, 2));
                end else begin
                    r.req = REQ_UNUSED;
                end
                // wait for all reads to drain before this one
                if (counted == 0 || $urandom_range(0, 99) == 0) r.drain = 1'b1;
                atom_reqs.push_back(r);
                if (r.req != REQ_UNUSED && !(r.req == REQ_WRITE && r.row == ROW_UNUSED)) begin
                    counted++;
                end
                if ($urandom_range(0, 299) == 0) begin
                    foreach (hot_cell[h]) hot_cell[h] = CELL_IDX_W'($urandom());
                end
            end
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (atom_reqs.size() != 0 || start || sums_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("PASS cell_moment_vector_accumulator_top");
        end else begin
            $display("FAIL cell_moment_vector_accumulator_top");
        end
        $finish;
    end

endmodule
